### hw/rtl/sste_pkg.sv
`default_nettype none

package sste_pkg;

  // Operation codes carried by opcode_i
  typedef enum logic [2:0] {
    OP_INSERT  = 3'd0,
    OP_DELETE  = 3'd1,
    OP_MEMBER  = 3'd2,
    OP_SIZE    = 3'd3,
    OP_UNION   = 3'd4,
    OP_ISECT   = 3'd5,
    OP_DIFF    = 3'd6,
    OP_SYMDIFF = 3'd7
  } sste_op_e;

  localparam int unsigned ValueWidth = 32;
  localparam int unsigned CountWidth = 7;

endpackage

`default_nettype wire

### hw/rtl/sste_ram.sv
`default_nettype none

module sste_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

### hw/rtl/sorted_set_table_engine_unit.sv
// Sorted-set table engine. Holds SET_COUNT sets of signed 32-bit values, each a sorted,
// duplicate-free array of up to CAPACITY entries, all empty after reset. Each request
// carries one operation on set A and returns exactly one result with A's size afterwards.
// Every operation but size is done as one walk of a shared compare unit over the two sorted
// sources (set B, or the single request value for insert, delete and member), one
// element a cycle, into a scratch buffer, followed by a copy back into A at one entry
// a cycle. Size reads A's size alone and skips the walk; member or a full insert skip the
// copy. Each memory has a single read port.
// in_ready_o is high only when no request is at work; a finished result may wait in the
// output register while the next request is taken.

`default_nettype none

module sorted_set_table_engine_unit #(
  parameter int unsigned SET_COUNT = 8,
  parameter int unsigned CAPACITY  = 64
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire sste_pkg::sste_op_e                opcode_i,
  input  wire logic [2:0]                        first_set_i,
  input  wire logic [2:0]                        second_set_i,
  input  wire logic signed [sste_pkg::ValueWidth-1:0] value_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic [sste_pkg::CountWidth-1:0]        set_count_o,
  output logic                                   is_member_o,
  output logic                                   overflow_o
);

  import sste_pkg::*;

  localparam int unsigned SW = (SET_COUNT > 1) ? $clog2(SET_COUNT) : 1;
  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned NW = $clog2(2 * CAPACITY + 1);
  localparam int unsigned ED = SET_COUNT * CAPACITY;
  localparam int unsigned EW = $clog2(ED);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_SZA  = 6'b000010,
    ST_SZB  = 6'b000100,
    ST_STEP = 6'b001000,
    ST_COPY = 6'b010000,
    ST_FIN  = 6'b100000
  } state_e;

  // set index wraps modulo SET_COUNT for SET_COUNT of 2 up to 127
  function automatic logic [SW-1:0] pick_set(input logic [2:0] raw);
    logic [6:0] v;
    v = {4'b0, raw};
    for (int k = 0; k < 4; k++) begin
      if (v >= 7'(SET_COUNT)) v = v - 7'(SET_COUNT);
    end
    return v[SW-1:0];
  endfunction

  state_e                  state_q, state_d;
  sste_op_e                op_q;
  logic [SW-1:0]           a_q, b_q;
  logic signed [ValueWidth-1:0] x_q;
  logic [CW-1:0]           na_q, na_d, nb_q, nb_d;
  logic [CW-1:0]           i_q, i_d, j_q, j_d, k_q, k_d;
  logic [NW-1:0]           n_q, n_d;
  logic [CW-1:0]           sizes_q [SET_COUNT];
  logic                    out_valid_q;
  logic [CountWidth-1:0]   set_count_q;
  logic                    is_member_q, overflow_q;

  logic                    accept;
  logic [SW-1:0]           size_idx;
  logic [CW-1:0]           size_rd;
  logic                    keep_a, keep_b, keep_both, use_val, write_back;
  logic [ValueWidth-1:0]   rd_a, rd_b, buf_rd;
  logic signed [ValueWidth-1:0] ra, rb, emit_val;
  logic                    emit, buf_we, store_we, size_we, out_load;
  logic [CW-1:0]           kept;
  logic [CW+CountWidth-1:0] cnt_ext;
  logic [EW-1:0]           addr_a, addr_b, addr_w;
  logic                    av, bv;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == ST_IDLE);

  // one shared read of the size table
  assign size_idx = (state_q == ST_SZB) ? b_q : a_q;
  assign size_rd  = sizes_q[size_idx];

  // source selection per operation
  always_comb begin
    keep_a = 1'b0; keep_b = 1'b0; keep_both = 1'b0;
    use_val = 1'b0; write_back = 1'b1;
    unique case (op_q)
      OP_INSERT:  begin keep_a = 1'b1; keep_b = 1'b1; keep_both = 1'b1; use_val = 1'b1; end
      OP_DELETE:  begin keep_a = 1'b1; use_val = 1'b1; end
      OP_MEMBER:  begin keep_both = 1'b1; use_val = 1'b1; write_back = 1'b0; end
      OP_SIZE:    begin write_back = 1'b0; end
      OP_UNION:   begin keep_a = 1'b1; keep_b = 1'b1; keep_both = 1'b1; end
      OP_ISECT:   begin keep_both = 1'b1; end
      OP_DIFF:    begin keep_a = 1'b1; end
      OP_SYMDIFF: begin keep_a = 1'b1; keep_b = 1'b1; end
      default:    begin write_back = 1'b0; end
    endcase
  end

  assign ra   = $signed(rd_a);
  assign rb   = use_val ? x_q : $signed(rd_b);
  assign av   = (i_q < na_q);
  assign bv   = (j_q < nb_q);
  assign kept = (n_q > NW'(CAPACITY)) ? CW'(CAPACITY) : n_q[CW-1:0];

  // sequencer around the shared compare unit
  always_comb begin
    state_d  = state_q;
    na_d     = na_q;
    nb_d     = nb_q;
    i_d      = i_q;
    j_d      = j_q;
    k_d      = k_q;
    n_d      = n_q;
    emit     = 1'b0;
    emit_val = ra;
    store_we = 1'b0;
    size_we  = 1'b0;
    out_load = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_SZA;
          n_d     = '0;
        end
      end
      ST_SZA: begin
        na_d    = size_rd;
        state_d = (op_q == OP_SIZE) ? ST_FIN : ST_SZB;
      end
      ST_SZB: begin
        nb_d    = use_val ? CW'(1) : size_rd;
        i_d     = '0;
        j_d     = '0;
        state_d = ST_STEP;
      end
      ST_STEP: begin
        priority if (!av && !bv) begin
          if (write_back && !(op_q == OP_INSERT && n_q > NW'(CAPACITY))) begin
            state_d = ST_COPY;
            k_d     = '0;
          end else begin
            state_d = ST_FIN;
          end
        end else if (!bv || (av && ra < rb)) begin
          emit = keep_a;
          i_d  = i_q + CW'(1);
        end else if (!av || ra > rb) begin
          emit     = keep_b;
          emit_val = rb;
          j_d      = j_q + CW'(1);
        end else begin
          emit = keep_both;
          i_d  = i_q + CW'(1);
          j_d  = j_q + CW'(1);
        end
        if (emit) n_d = n_q + NW'(1);
      end
      ST_COPY: begin
        if (k_q < kept) begin
          store_we = 1'b1;
          k_d      = k_q + CW'(1);
        end else begin
          size_we = 1'b1;
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign buf_we  = emit && (n_q < NW'(CAPACITY));
  assign addr_a  = EW'(a_q) * EW'(CAPACITY) + EW'(i_d[AW-1:0]);
  assign addr_b  = EW'(b_q) * EW'(CAPACITY) + EW'(j_d[AW-1:0]);
  assign addr_w  = EW'(a_q) * EW'(CAPACITY) + EW'(k_q[AW-1:0]);
  assign cnt_ext = {{CountWidth{1'b0}}, size_rd};

  // element store, duplicated for a second read port
  sste_ram #(.WIDTH(ValueWidth), .DEPTH(ED)) u_store_a (
    .clk_i   (clk_i),
    .we_i    (store_we),
    .waddr_i (addr_w),
    .wdata_i (buf_rd),
    .raddr_i (addr_a),
    .rdata_o (rd_a)
  );

  sste_ram #(.WIDTH(ValueWidth), .DEPTH(ED)) u_store_b (
    .clk_i   (clk_i),
    .we_i    (store_we),
    .waddr_i (addr_w),
    .wdata_i (buf_rd),
    .raddr_i (addr_b),
    .rdata_o (rd_b)
  );

  // merge scratch buffer
  sste_ram #(.WIDTH(ValueWidth), .DEPTH(CAPACITY)) u_merge_buf (
    .clk_i   (clk_i),
    .we_i    (buf_we),
    .waddr_i (n_q[AW-1:0]),
    .wdata_i (emit_val),
    .raddr_i (k_d[AW-1:0]),
    .rdata_o (buf_rd)
  );

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      n_q         <= '0;
      for (int s = 0; s < SET_COUNT; s++) sizes_q[s] <= '0;
    end else begin
      state_q <= state_d;
      n_q     <= n_d;
      if (size_we) sizes_q[a_q] <= kept;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q <= opcode_i;
      a_q  <= pick_set(first_set_i);
      b_q  <= pick_set(second_set_i);
      x_q  <= value_i;
    end
    na_q <= na_d;
    nb_q <= nb_d;
    i_q  <= i_d;
    j_q  <= j_d;
    k_q  <= k_d;
    if (out_load) begin
      set_count_q <= cnt_ext[CountWidth-1:0];
      is_member_q <= (op_q == OP_MEMBER) && (n_q == NW'(1));
      overflow_q  <= (n_q > NW'(CAPACITY));
    end
  end

  assign out_valid_o = out_valid_q;
  assign set_count_o = set_count_q;
  assign is_member_o = is_member_q;
  assign overflow_o  = overflow_q;

  // checks
  a_buf_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    buf_we |-> (n_q < NW'(CAPACITY)))
    else $error("merge buffer written past capacity");

  a_copy_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_COPY) |-> (k_q <= kept))
    else $error("copy ran past kept count");

  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_STEP) |-> (i_q <= na_q && j_q <= nb_q))
    else $error("merge walk past end of source");

  a_result_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_FIN))
    else $error("result raised outside finish step");

  a_size_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    size_we |=> (sizes_q[a_q] <= CW'(CAPACITY)))
    else $error("set size above capacity");

endmodule

`default_nettype wire
